// ===== hw/rtl/tmc_pkg.sv =====
`timescale 1ns / 1ps
package tmc_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W      = $clog2(CELLS + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_ENABLE = 2'd2;

   localparam logic [2:0] CMD_PUT     = 3'd0;
   localparam logic [2:0] CMD_NEWLINE = 3'd1;
   localparam logic [2:0] CMD_CLEAR   = 3'd2;
   localparam logic [2:0] CMD_SET     = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_SET,
      OP_READ,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] char_code;
      logic [6:0] col;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_loc;
      logic        cursor_hidden;
      logic [7:0]  cell_char;
      logic [7:0]  cell_color;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         char_code;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [ADDR_W-1:0]  addr;
   } cmd_type;

   typedef struct packed {
      logic [3:0] fg_color;
      logic [3:0] bg_color;
      logic       cursor_enable;
   } cfg_type;

endpackage

// ===== hw/rtl/tmc_front.sv =====
`timescale 1ns / 1ps
module tmc_front
   import tmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wp_ff, wp_in;
   logic [Q_PTR_W-1:0]   rp_ff, rp_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type              dec;
   logic [COL_W-1:0]     col_c;
   logic [ROW_W-1:0]     row_c;
   logic                 wr, rd;

   always_comb begin
      if (int'(req_data.col) >= COLUMNS) begin
         col_c = COL_W'(COLUMNS - 1);
      end else begin
         col_c = COL_W'(req_data.col);
      end
      if (int'(req_data.row) >= ROWS) begin
         row_c = ROW_W'(ROWS - 1);
      end else begin
         row_c = ROW_W'(req_data.row);
      end
      dec.char_code = req_data.char_code;
      dec.col       = col_c;
      dec.row       = row_c;
      dec.addr      = ADDR_W'(int'(row_c) * COLUMNS + int'(col_c));
      case (req_data.command)
         CMD_PUT:     dec.op = OP_PUT;
         CMD_NEWLINE: dec.op = OP_NEWLINE;
         CMD_CLEAR:   dec.op = OP_CLEAR;
         CMD_SET:     dec.op = OP_SET;
         CMD_READ:    dec.op = OP_READ;
         default:     dec.op = OP_NOP;
      endcase
   end

   assign full      = hold || (int'(cnt_ff) == Q_DEPTH);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];
   assign wr        = push && !full;
   assign rd        = cmd_pop && cmd_valid;

   always_comb begin
      wp_in  = wr ? Q_PTR_W'(wp_ff + 1'b1) : wp_ff;
      rp_in  = rd ? Q_PTR_W'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (wr && !rd) begin
         cnt_in = Q_CNT_W'(cnt_ff + 1'b1);
      end else if (rd && !wr) begin
         cnt_in = Q_CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         q_ff[wp_ff] <= dec;
      end
   end

endmodule

// ===== hw/rtl/tmc_back.sv =====
`timescale 1ns / 1ps
module tmc_back
   import tmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    init_busy,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_data
);

   logic [15:0]          mem [CELLS];
   logic [15:0]          rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa, mem_ra;
   logic [15:0]          mem_wd;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic                 mv_valid_ff, mv_valid_in;
   logic [ADDR_W-1:0]    mv_dst_ff, mv_dst_in;

   rsp_type              rq_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   rq_wp_ff, rq_rp_ff;
   logic [Q_CNT_W-1:0]   rq_cnt_ff, rq_cnt_in;
   logic                 rq_push, rq_pop;
   rsp_type              rq_data;
   logic [15:0]          blank;
   logic                 rq_room;

   localparam logic [ADDR_W-1:0] LAST_ROW_POS = ADDR_W'(MOVE_CELLS);

   assign blank     = {cfg.bg_color, cfg.fg_color, 8'h00};
   assign rq_room   = (int'(rq_cnt_ff) < Q_DEPTH);
   assign init_busy = (state_ff == ST_INIT);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pos_in      = pos_ff;
      mv_valid_in = 1'b0;
      mv_dst_in   = mv_dst_ff;
      mem_we      = 1'b0;
      mem_wa      = pos_ff;
      mem_wd      = blank;
      mem_ra      = cmd.addr;
      cmd_pop     = 1'b0;
      rq_push     = 1'b0;
      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[ADDR_W-1:0];
            mem_wd = '0;
            if (int'(cnt_ff) == CELLS - 1) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (cmd_valid && rq_room) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_PUT: begin
                     mem_we = 1'b1;
                     mem_wd = {blank[15:8], cmd.char_code};
                     if (int'(col_ff) == COLUMNS - 1) begin
                        col_in = '0;
                        if (int'(row_ff) == ROWS - 1) begin
                           pos_in   = LAST_ROW_POS;
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in  = ROW_W'(row_ff + 1'b1);
                           pos_in  = ADDR_W'(pos_ff + 1'b1);
                           rq_push = 1'b1;
                        end
                     end else begin
                        col_in  = COL_W'(col_ff + 1'b1);
                        pos_in  = ADDR_W'(pos_ff + 1'b1);
                        rq_push = 1'b1;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     if (int'(row_ff) == ROWS - 1) begin
                        pos_in   = LAST_ROW_POS;
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in  = ROW_W'(row_ff + 1'b1);
                        pos_in  = ADDR_W'(int'(pos_ff) - int'(col_ff) + COLUMNS);
                        rq_push = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     pos_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  OP_SET: begin
                     col_in  = cmd.col;
                     row_in  = cmd.row;
                     pos_in  = cmd.addr;
                     rq_push = 1'b1;
                  end
                  OP_READ: begin
                     state_in = ST_READ_WAIT;
                  end
                  default: begin
                     rq_push = 1'b1;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rq_push  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            if (mv_valid_ff) begin
               mem_we = 1'b1;
               mem_wa = mv_dst_ff;
               mem_wd = rd_data_ff;
            end
            if (int'(cnt_ff) < MOVE_CELLS) begin
               mem_ra      = ADDR_W'(int'(cnt_ff) + COLUMNS);
               mv_valid_in = 1'b1;
               mv_dst_in   = cnt_ff[ADDR_W-1:0];
               cnt_in      = CNT_W'(cnt_ff + 1'b1);
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[ADDR_W-1:0];
            if (int'(cnt_ff) == CELLS - 1) begin
               rq_push  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = CNT_W'(cnt_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rq_data.cursor_loc    = 11'(pos_in);
      rq_data.cursor_hidden = !cfg.cursor_enable;
      if (state_ff == ST_READ_WAIT) begin
         rq_data.cell_char  = rd_data_ff[7:0];
         rq_data.cell_color = rd_data_ff[15:8];
      end else begin
         rq_data.cell_char  = '0;
         rq_data.cell_color = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         cnt_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         pos_ff      <= '0;
         mv_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pos_ff      <= pos_in;
         mv_valid_ff <= mv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_dst_ff <= mv_dst_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign empty    = (rq_cnt_ff == '0);
   assign rsp_data = rq_ff[rq_rp_ff];
   assign rq_pop   = pop && !empty;

   always_comb begin
      rq_cnt_in = rq_cnt_ff;
      if (rq_push && !rq_pop) begin
         rq_cnt_in = Q_CNT_W'(rq_cnt_ff + 1'b1);
      end else if (rq_pop && !rq_push) begin
         rq_cnt_in = Q_CNT_W'(rq_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wp_ff  <= '0;
         rq_rp_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         if (rq_push) begin
            rq_wp_ff <= Q_PTR_W'(rq_wp_ff + 1'b1);
         end
         if (rq_pop) begin
            rq_rp_ff <= Q_PTR_W'(rq_rp_ff + 1'b1);
         end
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wp_ff] <= rq_data;
      end
   end

endmodule

// ===== hw/rtl/text_mode_console.sv =====
`timescale 1ns / 1ps
// Text-mode console: a store of ROWS x COLUMNS character/color cells and a cursor.
// Requests enter through push/full with req_data; results leave through empty/pop
// with rsp_data, one result per request, in request order. Colors and cursor enable
// are written through the csr_ port (csr_ready is always high); the user must write
// them only while idle, the block does not enforce it. A two-entry command queue
// separates decode from execution, and a two-entry result queue lets requests keep
// flowing while the receiver stalls pop. A request is registered in the command
// queue, then executed with its result registered in the result queue; read cell
// also passes the cell store's registered read port. Throughput: one request per
// cycle for the short commands (put char, newline without scroll, set cursor, unused
// codes) while results are popped; read cell waits on the store read before the
// next request. Clear writes every cell blank, one store write per cycle. A newline
// or wrap that scrolls does (ROWS-1)*COLUMNS pipelined cell moves, then COLUMNS
// blank writes for the last row. After reset the store is zeroed in one pass over
// all CELLS cells (2000 at 80x25); full stays high during that pass, configuration
// writes are taken as usual. When pop stalls, the result queue fills and full rises.
module text_mode_console
   import tmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    init_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FG_COLOR:      cfg_in.fg_color      = csr_wdata[3:0];
            CSR_BG_COLOR:      cfg_in.bg_color      = csr_wdata[3:0];
            CSR_CURSOR_ENABLE: cfg_in.cursor_enable = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color      <= 4'd2;
         cfg_ff.bg_color      <= 4'd0;
         cfg_ff.cursor_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (init_busy),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .init_busy (init_busy),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (int'(rsp_data.cursor_loc) < CELLS))
      else $error("cursor position beyond screen");

   a_hidden: assert property (@(posedge clock) disable iff (reset)
      (!empty && !$past(csr_valid)) |-> (rsp_data.cursor_hidden == !cfg_ff.cursor_enable))
      else $error("cursor hidden flag disagrees with enable");

   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> (full && !cmd_pop))
      else $error("request taken during store clearing");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import tmc_pkg::*;

   localparam int LIMIT_CYCLES = 4_000_000;
   localparam int DRAIN_CYCLES = CELLS + 2 * COLUMNS + 32;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_REPORTS  = 40;
   localparam int COL_FIELD_MAX = 127;
   localparam int ROW_FIELD_MAX = 31;
   localparam logic [2:0] CMD_FIRST_SPARE = CMD_READ + 3'd1;
   localparam logic [2:0] CMD_LAST_SPARE  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   req_type               req_data = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int cycle_count = 0;
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   logic hold_start = 1'b0;

   rsp_type pending_results[$];

   logic [15:0] screen_cells [CELLS];
   int          cursor_col;
   int          cursor_row;
   logic [3:0]  fg_color;
   logic [3:0]  bg_color;
   logic        cursor_enable;

   text_mode_console u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic logic [15:0] blank_cell();
      return {bg_color, fg_color, 8'h00};
   endfunction

   function automatic void reset_console_state();
      for (int i = 0; i < CELLS; i++) begin
         screen_cells[i] = 16'h0000;
      end
      cursor_col    = 0;
      cursor_row    = 0;
      fg_color      = 4'd2;
      bg_color      = 4'd0;
      cursor_enable = 1'b1;
   endfunction

   function automatic void advance_line();
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= ROWS) begin
         cursor_row = ROWS - 1;
         for (int i = 0; i < MOVE_CELLS; i++) begin
            screen_cells[i] = screen_cells[i + COLUMNS];
         end
         for (int i = 0; i < COLUMNS; i++) begin
            screen_cells[MOVE_CELLS + i] = blank_cell();
         end
      end
   endfunction

   function automatic int clamp_index(input int value, input int limit);
      return (value >= limit) ? limit - 1 : value;
   endfunction

   function automatic rsp_type predict_console_result(input req_type item);
      rsp_type    result;
      int         pos;
      logic [15:0] cell_word;
      result = '0;
      case (item.command)
         CMD_PUT: begin
            pos = cursor_col + cursor_row * COLUMNS;
            screen_cells[pos] = blank_cell() | {8'h00, item.char_code};
            cursor_col++;
            if (cursor_col >= COLUMNS) begin
               advance_line();
            end
         end
         CMD_NEWLINE: begin
            advance_line();
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen_cells[i] = blank_cell();
            end
            cursor_col = 0;
            cursor_row = 0;
         end
         CMD_SET: begin
            cursor_col = clamp_index(int'(item.col), COLUMNS);
            cursor_row = clamp_index(int'(item.row), ROWS);
         end
         CMD_READ: begin
            pos  = clamp_index(int'(item.col), COLUMNS)
                 + clamp_index(int'(item.row), ROWS) * COLUMNS;
            cell_word = screen_cells[pos];
            result.cell_char  = cell_word[7:0];
            result.cell_color = cell_word[15:8];
         end
         default: begin
         end
      endcase
      pos = cursor_col + cursor_row * COLUMNS;
      result.cursor_loc    = pos[10:0];
      result.cursor_hidden = ~cursor_enable;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_REPORTS) begin
         $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
                  what, cycle_count, got, want);
      end
      error_count++;
   endtask

   // result checker and pop driver
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_data), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.cursor_loc !== want.cursor_loc)
               report_mismatch("cursor_loc", 32'(rsp_data.cursor_loc),
                               32'(want.cursor_loc));
            if (rsp_data.cursor_hidden !== want.cursor_hidden)
               report_mismatch("cursor_hidden", 32'(rsp_data.cursor_hidden),
                               32'(want.cursor_hidden));
            if (rsp_data.cell_char !== want.cell_char)
               report_mismatch("cell_char", 32'(rsp_data.cell_char),
                               32'(want.cell_char));
            if (rsp_data.cell_color !== want.cell_color)
               report_mismatch("cell_color", 32'(rsp_data.cell_color),
                               32'(want.cell_color));
         end
      end
      if (reset || hold_left != 0) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_results.push_back(predict_console_result(item));
   endtask

   task automatic send_command(input logic [2:0] command, input int char_code,
                               input int col, input int row);
      req_type item;
      item.command   = command;
      item.char_code = char_code[7:0];
      item.col       = col[6:0];
      item.row       = row[4:0];
      send_request(item);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_FG_COLOR:      fg_color = data;
         CSR_BG_COLOR:      bg_color = data;
         CSR_CURSOR_ENABLE: cursor_enable = data[0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic set_colors(input int fg, input int bg, input int enable);
      csr_write(CSR_FG_COLOR, fg[3:0]);
      csr_write(CSR_BG_COLOR, bg[3:0]);
      csr_write(CSR_CURSOR_ENABLE, enable[3:0]);
   endtask

   function automatic req_type random_request();
      req_type item;
      int      pick;
      pick           = int'($urandom_range(99));
      item.char_code = 8'($urandom_range(255));
      item.col = 7'(($urandom_range(9) < 8) ? $urandom_range(COLUMNS - 1)
                                            : $urandom_range(COL_FIELD_MAX));
      item.row = 5'(($urandom_range(9) < 8) ? $urandom_range(ROWS - 1)
                                            : $urandom_range(ROW_FIELD_MAX));
      if (pick < 46)      item.command = CMD_PUT;
      else if (pick < 52) item.command = CMD_NEWLINE;
      else if (pick < 53) item.command = CMD_CLEAR;
      else if (pick < 70) item.command = CMD_SET;
      else if (pick < 96) item.command = CMD_READ;
      else item.command = 3'($urandom_range(CMD_LAST_SPARE, CMD_FIRST_SPARE));
      return item;
   endfunction

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_command(CMD_READ, 0, 0, 0);
      send_command(CMD_PUT, 'h41, 0, 0);
      send_command(CMD_READ, 0, 0, 0);
      send_command(CMD_SET, 0, COL_FIELD_MAX, ROW_FIELD_MAX);
      send_command(CMD_READ, 0, COL_FIELD_MAX, ROW_FIELD_MAX);
      // put in the last cell: wraps and scrolls
      send_command(CMD_PUT, 'hFF, 0, 0);
      send_command(CMD_READ, 0, COLUMNS - 1, ROWS - 2);
      send_command(CMD_READ, 0, COLUMNS - 1, ROWS - 1);
      send_command(CMD_NEWLINE, 0, 0, 0);
      send_command(CMD_SET, 0, COLUMNS, ROWS);
      send_command(CMD_SET, 0, 0, 0);
      send_command(CMD_NEWLINE, 0, 0, 0);
      send_command(CMD_PUT, 'h00, 0, 0);
      send_command(CMD_PUT, 'h20, 0, 0);
      send_command(CMD_PUT, 'hDF, 0, 0);
      for (int c = CMD_FIRST_SPARE; c <= CMD_LAST_SPARE; c++) begin
         send_command(c[2:0], $urandom_range(255), $urandom_range(COL_FIELD_MAX),
                      $urandom_range(ROW_FIELD_MAX));
      end
      wait_idle();
      set_colors(15, 15, 0);
      csr_write(CSR_SPARE, 4'hF);
      send_command(CMD_CLEAR, 0, 0, 0);
      send_command(CMD_READ, 0, COLUMNS / 2, ROWS / 2);
      send_command(CMD_PUT, 'h7F, 0, 0);
      send_command(CMD_READ, 0, 0, 0);
      wait_idle();
      set_colors(0, 0, 1);
      send_command(CMD_CLEAR, 0, 0, 0);
      send_command(CMD_READ, 0, COL_FIELD_MAX, 0);
      wait_idle();
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      int burst;
      int sent;
      req_type item;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 3) begin
            burst = $urandom_range(90, 10);
            repeat (burst) begin
               item = random_request();
               item.command = CMD_PUT;
               send_request(item);
               sent++;
            end
         end else begin
            send_request(random_request());
            sent++;
         end
      end
      wait_idle();
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_backpressure();
      req_type item;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (80) begin
         item = random_request();
         if (item.command == CMD_CLEAR) item.command = CMD_PUT;
         send_request(item);
      end
      wait_idle();
   endtask

   initial begin
      reset_console_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      set_colors(15, 0, 0);
      test_random(540, 21, 72);
      set_colors(0, 15, 1);
      test_random(540, 72, 21);
      set_colors($urandom_range(15), $urandom_range(15), $urandom_range(1));
      test_random(540, 0, 0);
      test_backpressure();
      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tmc_pkg.sv
hw/rtl/tmc_front.sv
hw/rtl/tmc_back.sv
hw/rtl/text_mode_console.sv
tb/sv/testbench.sv
